FILE: src/line_follow_pid_drive_macros.svh
// assertion shorthands for the line follower
`ifndef LINE_FOLLOW_PID_DRIVE_MACROS_SVH
`define LINE_FOLLOW_PID_DRIVE_MACROS_SVH

// same-cycle implication, off during reset
`define LFPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line_follow_pid_drive: property violated");

// next-cycle implication, off during reset
`define LFPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line_follow_pid_drive: property violated");

`endif

FILE: src/lfpd_pkg.sv
`timescale 1ns / 1ps

package lfpd_pkg;

  localparam int unsigned THR_BITS  = 10;
  localparam int unsigned GAIN_BITS = 16;
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  // register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_BASE_SPEED  = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_THRESHOLD   = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CRUISE      = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SHARP_SPEED = 3'd6;

  // register reset values
  localparam logic [GAIN_BITS-1:0] GAIN_P_RST      = 16'd3840;
  localparam logic [GAIN_BITS-1:0] GAIN_I_RST      = 16'd15;
  localparam logic [GAIN_BITS-1:0] GAIN_D_RST      = 16'd512;
  localparam logic [7:0]           BASE_SPEED_RST  = 8'd80;
  localparam logic [THR_BITS-1:0]  THRESHOLD_RST   = 10'd40;
  localparam logic [7:0]           CRUISE_RST      = 8'd100;
  localparam logic [7:0]           SHARP_SPEED_RST = 8'd50;

  typedef enum logic [2:0] {
    ACT_CRUISE     = 3'd0,
    ACT_PID        = 3'd1,
    ACT_TURN_LEFT  = 3'd2,
    ACT_TURN_RIGHT = 3'd3,
    ACT_SHARP_LEFT = 3'd4,
    ACT_HOLD       = 3'd5,
    ACT_TURN_WAIT  = 3'd6
  } action_t;

  typedef struct packed {
    logic       right_rev;
    logic       left_rev;
    logic [7:0] right;
    logic [7:0] left;
  } drive_t;

  typedef struct packed {
    logic [4:0]        pattern;
    logic signed [3:0] err;
  } sense_t;

  // position error for a known pattern, bit0 leftmost
  function automatic logic [4:0] pattern_error(input logic [4:0] pat);
    logic [4:0] res;  // {known, error}
    case (pat)
      5'd16:   res = {1'b1, 4'sd4};
      5'd1:    res = {1'b1, -4'sd4};
      5'd24:   res = {1'b1, 4'sd3};
      5'd3:    res = {1'b1, -4'sd3};
      5'd8:    res = {1'b1, 4'sd2};
      5'd2:    res = {1'b1, -4'sd2};
      5'd12:   res = {1'b1, 4'sd1};
      5'd6:    res = {1'b1, -4'sd1};
      5'd4:    res = {1'b1, 4'sd0};
      default: res = 5'd0;
    endcase
    return res;
  endfunction

endpackage

FILE: src/lfpd_in_if.sv
`timescale 1ns / 1ps

interface lfpd_in_if #(
  parameter int unsigned SENSOR_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SENSOR_BITS-1:0] sample_left_outer;
  logic [SENSOR_BITS-1:0] sample_left_inner;
  logic [SENSOR_BITS-1:0] sample_middle;
  logic [SENSOR_BITS-1:0] sample_right_inner;
  logic [SENSOR_BITS-1:0] sample_right_outer;

  modport source (
    output valid, sample_left_outer, sample_left_inner, sample_middle,
           sample_right_inner, sample_right_outer,
    input  ready
  );
  modport sink (
    input  valid, sample_left_outer, sample_left_inner, sample_middle,
           sample_right_inner, sample_right_outer,
    output ready
  );
endinterface

FILE: src/lfpd_out_if.sv
`timescale 1ns / 1ps

interface lfpd_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        left_duty;
  logic [7:0]        right_duty;
  logic              left_reverse;
  logic              right_reverse;
  logic [2:0]        action;
  logic [4:0]        line_pattern;
  logic signed [3:0] track_error;

  modport source (
    output valid, left_duty, right_duty, left_reverse, right_reverse, action,
           line_pattern, track_error,
    input  ready
  );
  modport sink (
    input  valid, left_duty, right_duty, left_reverse, right_reverse, action,
           line_pattern, track_error,
    output ready
  );
endinterface

FILE: src/lfpd_cfg_if.sv
`timescale 1ns / 1ps

interface lfpd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lfpd_pkg::CFG_ADDR_BITS-1:0]  addr;
  logic [lfpd_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

FILE: src/lfpd_sense.sv
`timescale 1ns / 1ps

module lfpd_sense #(
  parameter int unsigned SENSOR_BITS = 10
) (
  input  logic [4:0][SENSOR_BITS-1:0]        samples,
  input  logic [lfpd_pkg::THR_BITS-1:0]      threshold,
  input  logic signed [3:0]                  last_error,
  output lfpd_pkg::sense_t                   sense
);

  localparam int unsigned CMP_W =
    (SENSOR_BITS > lfpd_pkg::THR_BITS) ? SENSOR_BITS : lfpd_pkg::THR_BITS;

  logic [CMP_W-1:0] thr_x;
  logic [4:0]       pat;
  logic [4:0]       lut;

  assign thr_x = CMP_W'(threshold);

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      pat[i] = CMP_W'(samples[i]) > thr_x;
    end
  end

  assign lut = lfpd_pkg::pattern_error(pat);

  // unknown patterns keep the previous error
  assign sense.pattern = pat;
  assign sense.err     = lut[4] ? $signed(lut[3:0]) : last_error;

endmodule

FILE: src/lfpd_pid.sv
`timescale 1ns / 1ps

module lfpd_pid #(
  parameter int unsigned SUM_BITS = 16
) (
  input  logic [lfpd_pkg::GAIN_BITS-1:0] gain_p,
  input  logic [lfpd_pkg::GAIN_BITS-1:0] gain_i,
  input  logic [lfpd_pkg::GAIN_BITS-1:0] gain_d,
  input  logic [7:0]                     base_speed,
  input  logic signed [3:0]              err,
  input  logic signed [3:0]              last_error,
  input  logic signed [SUM_BITS-1:0]     error_sum,
  output logic signed [SUM_BITS-1:0]     sum_nxt,
  output logic [7:0]                     left_duty,
  output logic [7:0]                     right_duty
);

  localparam int unsigned PW = SUM_BITS + 20;
  localparam int unsigned IW = SUM_BITS + 17;

  logic signed [SUM_BITS:0]    sum_x;
  logic signed [SUM_BITS:0]    err_x;
  logic signed [SUM_BITS:0]    sum_wide;
  logic signed [SUM_BITS-1:0]  isum;
  logic signed [4:0]           err5;
  logic signed [4:0]           last5;
  logic signed [4:0]           diff;
  logic signed [16:0]          gp_s;
  logic signed [16:0]          gi_s;
  logic signed [16:0]          gd_s;
  logic signed [21:0]          p_prod;
  logic signed [IW-1:0]        i_prod;
  logic signed [21:0]          d_prod;
  logic signed [PW-1:0]        corr;
  logic signed [PW-1:0]        base_q;
  logic signed [PW-1:0]        left_q;
  logic signed [PW-1:0]        right_q;

  function automatic logic [7:0] clamp_duty(input logic signed [PW-1:0] q);
    logic [7:0] d;
    if (q[PW-1]) begin
      d = 8'd0;
    end else if (|q[PW-2:16]) begin
      d = 8'hff;
    end else begin
      d = q[15:8];
    end
    return d;
  endfunction

  // saturating integral
  assign sum_x    = {error_sum[SUM_BITS-1], error_sum};
  assign err_x    = {{(SUM_BITS-3){err[3]}}, err};
  assign sum_wide = sum_x + err_x;

  always_comb begin
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      isum = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      isum = sum_wide[SUM_BITS-1:0];
    end
  end

  assign err5  = {err[3], err};
  assign last5 = {last_error[3], last_error};
  assign diff  = err5 - last5;

  // gains are unsigned, so a zero sign bit goes in front
  assign gp_s = {1'b0, gain_p};
  assign gi_s = {1'b0, gain_i};
  assign gd_s = {1'b0, gain_d};

  assign p_prod = 22'(gp_s) * 22'(err5);
  assign i_prod = IW'(gi_s) * IW'(isum);
  assign d_prod = 22'(gd_s) * 22'(diff);

  assign corr   = PW'(p_prod) + PW'(i_prod) + PW'(d_prod);
  assign base_q = $signed(PW'({base_speed, 8'h00}));

  assign left_q  = base_q + corr;
  assign right_q = base_q - corr;

  assign sum_nxt    = isum;
  assign left_duty  = clamp_duty(left_q);
  assign right_duty = clamp_duty(right_q);

endmodule

FILE: src/line_follow_pid_drive.sv
`timescale 1ns / 1ps

// channel   role     handshake            word
// in_ch     sink     valid / ready        five line-sensor samples
// out_ch    source   valid / ready        wheel duties, reverse bits, action, pattern, error
// cfg_ch    sink     valid / ready (=1)   register index and write data
//
// one word per cycle sustained while out_ch is ready; a word taken goes first into the
// sample register, then into the result register, and leaves from there when taken
// the rate is set by the state loop: threshold, error lookup, the three gain
// products and the wheel clamps all sit between the sample register and the
// result register, and the loop state updates as each result is registered
// reset (rst_n low at a clock edge) clears the pipe and loop state, and sets the
// registers to their reset values; a stalled result holds in the result register
// while the next word waits in the sample register

`include "line_follow_pid_drive_macros.svh"

module line_follow_pid_drive #(
  parameter int unsigned SENSOR_BITS = 10,
  parameter int unsigned SUM_BITS    = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  lfpd_in_if.sink    in_ch,
  lfpd_out_if.source out_ch,
  lfpd_cfg_if.sink   cfg_ch
);

  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_LEFT  = 2'd1,
    TURN_RIGHT = 2'd2
  } turn_t;

  // configuration registers
  logic [lfpd_pkg::GAIN_BITS-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [7:0]                     base_speed_r, cruise_r, sharp_r;
  logic [lfpd_pkg::THR_BITS-1:0]  threshold_r;

  // sample stage
  logic                          s1_valid_r;
  logic [4:0][SENSOR_BITS-1:0]   samples_r;

  // result stage
  logic                    out_valid_r;
  lfpd_pkg::drive_t        out_drive_r;
  lfpd_pkg::action_t       out_action_r;
  logic [4:0]              out_pattern_r;
  logic signed [3:0]       out_err_r;

  // loop state
  logic signed [3:0]          last_error_r;
  logic signed [SUM_BITS-1:0] error_sum_r;
  logic [7:0]                 pid_left_r, pid_right_r;
  lfpd_pkg::drive_t           held_r;
  turn_t                      turn_r;

  // next values
  logic                       advance;
  logic                       in_take;
  lfpd_pkg::sense_t           sense;
  logic signed [SUM_BITS-1:0] sum_calc;
  logic [7:0]                 pid_left_calc, pid_right_calc;
  logic                       wait_c;
  lfpd_pkg::drive_t           drive_nxt;
  lfpd_pkg::action_t          action_nxt;
  logic signed [3:0]          err_out_nxt;
  logic signed [3:0]          last_error_nxt;
  logic signed [SUM_BITS-1:0] error_sum_nxt;
  logic [7:0]                 pid_left_nxt, pid_right_nxt;
  lfpd_pkg::drive_t           held_nxt;
  turn_t                      turn_nxt;

  // the sample stage moves on whenever the result register is free or drained
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  lfpd_sense #(
    .SENSOR_BITS(SENSOR_BITS)
  ) u_sense (
    .samples    (samples_r),
    .threshold  (threshold_r),
    .last_error (last_error_r),
    .sense      (sense)
  );

  lfpd_pid #(
    .SUM_BITS(SUM_BITS)
  ) u_pid (
    .gain_p     (gain_p_r),
    .gain_i     (gain_i_r),
    .gain_d     (gain_d_r),
    .base_speed (base_speed_r),
    .err        (sense.err),
    .last_error (last_error_r),
    .error_sum  (error_sum_r),
    .sum_nxt    (sum_calc),
    .left_duty  (pid_left_calc),
    .right_duty (pid_right_calc)
  );

  // a pivot turn waits until the middle sensor finds the line again
  assign wait_c = (turn_r != TURN_NONE) && !sense.pattern[2];

  always_comb begin
    drive_nxt      = held_r;
    action_nxt     = lfpd_pkg::ACT_HOLD;
    err_out_nxt    = sense.err;
    last_error_nxt = sense.err;
    error_sum_nxt  = sum_calc;
    pid_left_nxt   = pid_left_r;
    pid_right_nxt  = pid_right_r;
    turn_nxt       = TURN_NONE;

    if (wait_c) begin
      // turning wait: drive and loop state hold, the old error is shown
      action_nxt     = lfpd_pkg::ACT_TURN_WAIT;
      err_out_nxt    = last_error_r;
      last_error_nxt = last_error_r;
      error_sum_nxt  = error_sum_r;
      turn_nxt       = turn_r;
    end else begin
      case (sense.pattern) inside
        5'd0: begin
          drive_nxt  = '{right_rev: 1'b0, left_rev: 1'b0, right: cruise_r, left: cruise_r};
          action_nxt = lfpd_pkg::ACT_CRUISE;
        end
        5'd2, 5'd4, 5'd6, 5'd8, 5'd12: begin
          pid_left_nxt  = pid_left_calc;
          pid_right_nxt = pid_right_calc;
          drive_nxt     = '{right_rev: 1'b0, left_rev: 1'b0,
                            right: pid_right_calc, left: pid_left_calc};
          action_nxt    = lfpd_pkg::ACT_PID;
        end
        5'd3, 5'd7, 5'd15: begin
          drive_nxt  = '{right_rev: 1'b0, left_rev: 1'b0, right: pid_right_r, left: 8'd0};
          action_nxt = lfpd_pkg::ACT_TURN_LEFT;
          turn_nxt   = TURN_LEFT;
        end
        5'd24, 5'd28, 5'd30: begin
          drive_nxt  = '{right_rev: 1'b0, left_rev: 1'b0, right: 8'd0, left: pid_left_r};
          action_nxt = lfpd_pkg::ACT_TURN_RIGHT;
          turn_nxt   = TURN_RIGHT;
        end
        5'd5: begin
          // sharp left spins the left wheel backward
          drive_nxt  = '{right_rev: 1'b0, left_rev: 1'b1, right: pid_right_r, left: sharp_r};
          action_nxt = lfpd_pkg::ACT_SHARP_LEFT;
        end
        default: begin
          drive_nxt  = held_r;
          action_nxt = lfpd_pkg::ACT_HOLD;
        end
      endcase
    end
    held_nxt = drive_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= lfpd_pkg::GAIN_P_RST;
      gain_i_r     <= lfpd_pkg::GAIN_I_RST;
      gain_d_r     <= lfpd_pkg::GAIN_D_RST;
      base_speed_r <= lfpd_pkg::BASE_SPEED_RST;
      threshold_r  <= lfpd_pkg::THRESHOLD_RST;
      cruise_r     <= lfpd_pkg::CRUISE_RST;
      sharp_r      <= lfpd_pkg::SHARP_SPEED_RST;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      last_error_r <= '0;
      error_sum_r  <= '0;
      pid_left_r   <= '0;
      pid_right_r  <= '0;
      held_r       <= '0;
      turn_r       <= TURN_NONE;
    end else begin
      // register writes, unknown indexes are dropped
      if (cfg_ch.valid) begin
        unique case (cfg_ch.addr)
          lfpd_pkg::REG_GAIN_P:      gain_p_r     <= cfg_ch.data;
          lfpd_pkg::REG_GAIN_I:      gain_i_r     <= cfg_ch.data;
          lfpd_pkg::REG_GAIN_D:      gain_d_r     <= cfg_ch.data;
          lfpd_pkg::REG_BASE_SPEED:  base_speed_r <= cfg_ch.data[7:0];
          lfpd_pkg::REG_THRESHOLD:   threshold_r  <= cfg_ch.data[lfpd_pkg::THR_BITS-1:0];
          lfpd_pkg::REG_CRUISE:      cruise_r     <= cfg_ch.data[7:0];
          lfpd_pkg::REG_SHARP_SPEED: sharp_r      <= cfg_ch.data[7:0];
          default: ;
        endcase
      end

      // sample stage
      if (in_take) begin
        s1_valid_r <= 1'b1;
        samples_r  <= {in_ch.sample_right_outer, in_ch.sample_right_inner,
                       in_ch.sample_middle, in_ch.sample_left_inner,
                       in_ch.sample_left_outer};
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      // result stage and loop state
      if (advance) begin
        out_valid_r   <= 1'b1;
        out_drive_r   <= drive_nxt;
        out_action_r  <= action_nxt;
        out_pattern_r <= sense.pattern;
        out_err_r     <= err_out_nxt;
        last_error_r  <= last_error_nxt;
        error_sum_r   <= error_sum_nxt;
        pid_left_r    <= pid_left_nxt;
        pid_right_r   <= pid_right_nxt;
        held_r        <= held_nxt;
        turn_r        <= turn_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.left_duty     = out_drive_r.left;
  assign out_ch.right_duty    = out_drive_r.right;
  assign out_ch.left_reverse  = out_drive_r.left_rev;
  assign out_ch.right_reverse = out_drive_r.right_rev;
  assign out_ch.action        = out_action_r;
  assign out_ch.line_pattern  = out_pattern_r;
  assign out_ch.track_error   = out_err_r;

  // a word stuck in the sample stage only ever waits behind a full result register
  `LFPD_ASSERT_IMP(a_stall_cause, clk, rst_n, !in_ch.ready, s1_valid_r && out_valid_r && !out_ch.ready)
  // a word that is not a turning wait leaves its error as the loop error
  `LFPD_ASSERT_NXT(a_error_tracks, clk, rst_n, advance && !wait_c, last_error_r == out_err_r)
  // only a sharp left, or a hold that repeats one, reverses a wheel, and never the right one
  `LFPD_ASSERT_IMP(a_reverse_sharp, clk, rst_n, out_valid_r && (out_drive_r.left_rev || out_drive_r.right_rev), (out_action_r == lfpd_pkg::ACT_SHARP_LEFT || out_action_r == lfpd_pkg::ACT_HOLD) && !out_drive_r.right_rev)

endmodule
